>>> src/assert_macros.svh
// Assertion macros used by the formatter core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/jisf_pkg.sv
// Package: types, constants and states of the JSON indent stream formatter.
package jisf_pkg;

    // Parameter defaults
    localparam int MAX_INDENT_DEF = 7;
    localparam int DEPTH_MAX_DEF  = 255;

    // Register reset values and limits
    localparam logic [63:0] DELIM_BYTES_RESET = 64'h0000_0000_2020_2020;
    localparam logic [3:0]  DELIM_LEN_RESET   = 4'd4;
    localparam logic [3:0]  DELIM_LEN_MAX     = 4'd8;

    // Register indexes (decoded from paddr[3])
    localparam logic REG_DELIM_BYTES = 1'b0;
    localparam logic REG_DELIM_LEN   = 1'b1;

    // Request codes
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOS  = 1'b1;

    // Character codes
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT = 8'd33;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    // Emission phases of one transaction
    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_NL,
        S_IND,
        S_TAIL
    } phase_t;

endpackage

>>> src/json_indent_stream_formatter_core.sv
// Top level: JSON re-indenting byte stream formatter with APB register port.
//
// Each input transaction is taken only while the sequencer is idle, and the
// next waits until every output byte it causes is emitted: a plain byte
// gives itself, a control byte nothing, and a bracket or unquoted comma also
// a newline and min(depth, MAX_INDENT) * min(delim_len, 8) indent bytes. The
// rate is set by the single output byte register: one byte leaves per cycle
// while the consumer takes it, chosen by the phase sequencer and its shared
// level/position counter. The output register lets a finished byte wait for
// the consumer while the sequencer holds. Registers are written through APB
// at byte address 0 (delim_bytes, 64 bits) and 8 (delim_len); write only while idle.
`include "assert_macros.svh"

module json_indent_stream_formatter_core #(
    parameter int MAX_INDENT = jisf_pkg::MAX_INDENT_DEF,
    parameter int DEPTH_MAX  = jisf_pkg::DEPTH_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  jisf_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output jisf_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import jisf_pkg::*;

    localparam int DEPTH_W = $clog2(DEPTH_MAX + 1);
    localparam int LVL_W   = $clog2(MAX_INDENT + 1);

    // Configuration registers
    logic [63:0] delim_bytes_reg;
    logic [3:0]  delim_len_reg;

    // Formatter state
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               in_string_reg, in_string_next;

    // Sequencer registers
    phase_t             state_reg, state_next;
    logic [7:0]         ch_reg, ch_next;
    logic               has_nl_reg, has_nl_next;
    logic               has_tail_reg, has_tail_next;
    logic [LVL_W-1:0]   levels_reg, levels_next;
    logic [3:0]         len_reg, len_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [2:0]         pos_reg, pos_next;

    // Output register
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic       accept;
    logic       emit;
    logic       ind_nonempty;
    logic       ind_end;
    logic       is_open, is_close, is_ctrl, is_quote, is_comma;
    logic [DEPTH_W-1:0] depth_new;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       cfg_write;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign emit      = (state_reg != S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Classify the incoming byte
    assign is_open  = (in_data.char_byte == CH_LBRACE) || (in_data.char_byte == CH_LBRACK);
    assign is_close = (in_data.char_byte == CH_RBRACE) || (in_data.char_byte == CH_RBRACK);
    assign is_ctrl  = (in_data.char_byte < CTRL_LIMIT) || (in_data.char_byte == CH_DEL);
    assign is_quote = (in_data.char_byte == CH_QUOTE);
    assign is_comma = (in_data.char_byte == CH_COMMA);

    // Shared indent counter compares
    assign ind_nonempty = (levels_reg != '0) && (len_reg != 4'd0);
    assign ind_end = (({1'b0, pos_reg} + 4'd1) == len_reg)
                  && (({1'b0, lvl_reg} + 1'b1) == {1'b0, levels_reg});

    // Depth after the incoming item
    always_comb
    begin
        depth_new = depth_reg;
        priority if (in_data.req_type == REQ_EOS)
            depth_new = '0;
        else if (is_open && (depth_reg < DEPTH_W'(DEPTH_MAX)))
            depth_new = depth_reg + 1'b1;
        else if (is_close && (depth_reg != '0))
            depth_new = depth_reg - 1'b1;
        else
            depth_new = depth_reg;
    end

    // Next state: load a transaction, then advance through its phases
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        has_nl_next    = has_nl_reg;
        has_tail_next  = has_tail_reg;
        levels_next    = levels_reg;
        len_next       = len_reg;
        lvl_next       = lvl_reg;
        pos_next       = pos_reg;
        depth_next     = depth_reg;
        in_string_next = in_string_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next       = in_data.char_byte;
                    lvl_next      = '0;
                    pos_next      = '0;
                    len_next      = (delim_len_reg > DELIM_LEN_MAX) ? DELIM_LEN_MAX
                                                                    : delim_len_reg;
                    levels_next   = (depth_new < DEPTH_W'(MAX_INDENT))
                                  ? LVL_W'(depth_new) : LVL_W'(MAX_INDENT);
                    depth_next    = depth_new;
                    has_nl_next   = 1'b0;
                    has_tail_next = 1'b0;
                    priority if (in_data.req_type == REQ_EOS)
                    begin
                        state_next     = S_NL;
                        levels_next    = '0;
                        in_string_next = 1'b0;
                    end
                    else if (is_open)
                    begin
                        state_next  = S_HEAD;
                        has_nl_next = 1'b1;
                    end
                    else if (is_close)
                    begin
                        state_next    = S_NL;
                        has_tail_next = 1'b1;
                    end
                    else if (is_ctrl)
                        state_next = S_IDLE;
                    else
                    begin
                        state_next  = S_HEAD;
                        has_nl_next = is_comma && !in_string_reg;
                        if (is_quote)
                            in_string_next = !in_string_reg;
                    end
                end
            end
            S_HEAD:
            begin
                if (emit)
                    state_next = has_nl_reg ? S_NL : S_IDLE;
            end
            S_NL:
            begin
                if (emit)
                begin
                    priority if (ind_nonempty)
                        state_next = S_IND;
                    else if (has_tail_reg)
                        state_next = S_TAIL;
                    else
                        state_next = S_IDLE;
                end
            end
            S_IND:
            begin
                if (emit)
                begin
                    priority if (ind_end)
                        state_next = has_tail_reg ? S_TAIL : S_IDLE;
                    else if (({1'b0, pos_reg} + 4'd1) == len_reg)
                    begin
                        pos_next = '0;
                        lvl_next = lvl_reg + 1'b1;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
            end
            S_TAIL:
            begin
                if (emit)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs: byte and last flag of the current phase
    always_comb
    begin
        emit_byte = ch_reg;
        emit_last = 1'b0;
        unique case (state_reg)
            S_HEAD:
            begin
                emit_byte = ch_reg;
                emit_last = !has_nl_reg;
            end
            S_NL:
            begin
                emit_byte = CH_NL;
                emit_last = !ind_nonempty && !has_tail_reg;
            end
            S_IND:
            begin
                emit_byte = delim_bytes_reg[{pos_reg, 3'b000} +: 8];
                emit_last = ind_end && !has_tail_reg;
            end
            S_TAIL:
            begin
                emit_byte = ch_reg;
                emit_last = 1'b1;
            end
            default:
            begin
                emit_byte = ch_reg;
                emit_last = 1'b0;
            end
        endcase
    end

    // Advance sequencer and formatter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            in_string_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            in_string_reg <= in_string_next;
        end
    end

    // Hold transaction payload for the sequencer
    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        has_nl_reg   <= has_nl_next;
        has_tail_reg <= has_tail_next;
        levels_reg   <= levels_next;
        len_reg      <= len_next;
        lvl_reg      <= lvl_next;
        pos_reg      <= pos_next;
    end

    // Load the output register, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.out_byte <= emit_byte;
            out_data_reg.last     <= emit_last;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_bytes_reg <= DELIM_BYTES_RESET;
            delim_len_reg   <= DELIM_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3])
                REG_DELIM_BYTES: delim_bytes_reg <= pwdata;
                REG_DELIM_LEN:   delim_len_reg   <= pwdata[3:0];
                default:         delim_len_reg   <= delim_len_reg;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (paddr[3])
            REG_DELIM_BYTES: prdata = delim_bytes_reg;
            REG_DELIM_LEN:   prdata = {60'd0, delim_len_reg};
            default:         prdata = '0;
        endcase
    end

    // Checks
    `ASSERT_SAME(a_depth_bound, 1'b1, depth_reg <= DEPTH_W'(DEPTH_MAX), "depth beyond limit")
    `ASSERT_SAME(a_ind_range, state_reg == S_IND, ({1'b0, pos_reg} < len_reg) && (lvl_reg < levels_reg), "indent counter out of range")
    `ASSERT_NEXT(a_ctrl_drop, accept && (in_data.req_type == REQ_DATA) && is_ctrl && !is_open && !is_close, state_reg == S_IDLE, "control byte not dropped")
    `ASSERT_NEXT(a_last_ends, emit && emit_last, state_reg == S_IDLE, "last byte did not end the transaction")

endmodule

>>> bench/tb_json_indent_stream_formatter_core.sv
// Testbench: random and directed byte streams, predicted output checked per byte.
module tb_json_indent_stream_formatter_core;
    import jisf_pkg::*;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    localparam int TAIL_CYCLES = 20;
    localparam int DEEP_OPENS  = 30;
    localparam int DOC_ITEMS   = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // Formatter state as the bench predicts it
    logic [63:0] fmt_delim = DELIM_BYTES_RESET;
    logic [3:0]  fmt_delim_len = DELIM_LEN_RESET;
    int unsigned fmt_depth = 0;
    bit          fmt_quoted = 1'b0;

    in_item_t    pending_chars[$];
    out_item_t   line_bytes[$];
    out_item_t   expected_bytes[$];
    int          errors = 0;

    int          burst_left = 0;
    int          gap_left = 0;
    logic [7:0]  rx_tick = '0;

    json_indent_stream_formatter_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Append one byte to the output of the current transaction
    function automatic void emit_char(logic [7:0] b);
        out_item_t r;
        r.out_byte = b;
        r.last = 1'b0;
        line_bytes.push_back(r);
    endfunction

    // Append the indent for the current depth
    function automatic void emit_indent();
        int lvl;
        int w;
        lvl = (fmt_depth < MAX_INDENT_DEF) ? fmt_depth : MAX_INDENT_DEF;
        w = int'((fmt_delim_len > DELIM_LEN_MAX) ? DELIM_LEN_MAX : fmt_delim_len);
        for (int i = 0; i < lvl; i++)
            for (int j = 0; j < w; j++)
                emit_char(fmt_delim[8*j +: 8]);
    endfunction

    // Work out the bytes one input transaction produces and advance the state
    function automatic void format_char(in_item_t it);
        logic [7:0] ch;
        ch = it.char_byte;
        line_bytes.delete();
        if (it.req_type == REQ_EOS) begin
            emit_char(CH_NL);
            fmt_depth = 0;
            fmt_quoted = 1'b0;
        end
        else if (ch == CH_LBRACE || ch == CH_LBRACK) begin
            if (fmt_depth < DEPTH_MAX_DEF)
                fmt_depth++;
            emit_char(ch);
            emit_char(CH_NL);
            emit_indent();
        end
        else if (ch == CH_RBRACE || ch == CH_RBRACK) begin
            if (fmt_depth > 0)
                fmt_depth--;
            emit_char(CH_NL);
            emit_indent();
            emit_char(ch);
        end
        else begin
            if (!(ch < CTRL_LIMIT || ch == CH_DEL))
                emit_char(ch);
            if (ch == CH_QUOTE)
                fmt_quoted = ~fmt_quoted;
            if (ch == CH_COMMA && !fmt_quoted) begin
                emit_char(CH_NL);
                emit_indent();
            end
        end
        if (line_bytes.size() > 0)
            line_bytes[line_bytes.size()-1].last = 1'b1;
        foreach (line_bytes[k])
            expected_bytes.push_back(line_bytes[k]);
    endfunction

    // Driver: send pending transactions in bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                format_char(in_data);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    in_data <= pending_chars.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each output transaction and stall on a rotating pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_tick <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output byte=%h last=%b", $time,
                             out_data.out_byte, out_data.last);
                end
                else
                begin
                    if (out_data.out_byte !== expected_bytes[0].out_byte)
                    begin
                        errors++;
                        $display("%0t: out_byte expected %h actual %h", $time,
                                 expected_bytes[0].out_byte, out_data.out_byte);
                    end
                    if (out_data.last !== expected_bytes[0].last)
                    begin
                        errors++;
                        $display("%0t: last expected %b actual %b", $time,
                                 expected_bytes[0].last, out_data.last);
                    end
                    void'(expected_bytes.pop_front());
                end
            end
            rx_tick <= rx_tick + 1'b1;
            case (rx_mode_t'(rx_tick[7:6]))
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= ($urandom_range(1) == 1);
                RX_SPARSE: out_ready <= (rx_tick[1:0] == 2'b00);
                default:   out_ready <= ($urandom_range(3) != 0);
            endcase
        end
    end

    // Write one register through the APB port and mirror it in the predictor
    task automatic write_reg(logic reg_idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_DELIM_BYTES)
            fmt_delim = value;
        else
            fmt_delim_len = value[3:0];
    endtask

    task automatic queue_char(logic req, logic [7:0] ch);
        in_item_t it;
        it.req_type = req;
        it.char_byte = ch;
        pending_chars.push_back(it);
    endtask

    // Hold until every transaction is sent and every output byte is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_chars.size() != 0 || in_valid || expected_bytes.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Queue a mostly well-formed document with random content and some noise
    task automatic queue_random_doc(int count);
        int         roll;
        int         open_levels;
        bit         quoting;
        logic [7:0] ch;
        open_levels = 0;
        quoting = 1'b0;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(99);
            if (quoting)
            begin
                if (roll < 55)
                begin
                    do
                        ch = 8'($urandom_range(33, 126));
                    while (ch == CH_QUOTE);
                    queue_char(REQ_DATA, ch);
                end
                else if (roll < 70)
                begin
                    case ($urandom_range(4))
                        0: ch = CH_COMMA;
                        1: ch = CH_LBRACE;
                        2: ch = CH_LBRACK;
                        3: ch = CH_RBRACE;
                        default: ch = CH_RBRACK;
                    endcase
                    if (ch == CH_LBRACE || ch == CH_LBRACK)
                        open_levels++;
                    else if (ch != CH_COMMA && open_levels > 0)
                        open_levels--;
                    queue_char(REQ_DATA, ch);
                end
                else if (roll < 90)
                begin
                    queue_char(REQ_DATA, CH_QUOTE);
                    quoting = 1'b0;
                end
                else
                    queue_char(REQ_DATA, 8'($urandom_range(255)));
            end
            else
            begin
                if (roll < 20)
                begin
                    queue_char(REQ_DATA, $urandom_range(1) ? CH_LBRACE : CH_LBRACK);
                    open_levels++;
                end
                else if (roll < 35)
                begin
                    queue_char(REQ_DATA, $urandom_range(1) ? CH_RBRACE : CH_RBRACK);
                    if (open_levels > 0)
                        open_levels--;
                end
                else if (roll < 50)
                begin
                    queue_char(REQ_DATA, CH_QUOTE);
                    quoting = 1'b1;
                end
                else if (roll < 64)
                    queue_char(REQ_DATA, CH_COMMA);
                else if (roll < 84)
                    queue_char(REQ_DATA, $urandom_range(1) ? 8'($urandom_range(33, 126))
                                                           : 8'($urandom_range(128, 255)));
                else if (roll < 94)
                    queue_char(REQ_DATA, $urandom_range(1) ? 8'($urandom_range(0, 32))
                                                           : CH_DEL);
                else if (roll < 97)
                    queue_char(REQ_DATA, 8'($urandom_range(255)));
                else
                begin
                    queue_char(REQ_EOS, 8'($urandom_range(255)));
                    open_levels = 0;
                end
            end
        end
    endtask

    // Stimulus: directed items, deep nesting, then random documents
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: strings with brackets and commas, control and high bytes
        queue_char(REQ_DATA, CH_LBRACE);
        queue_char(REQ_DATA, CH_QUOTE);
        queue_char(REQ_DATA, 8'h61);
        queue_char(REQ_DATA, CH_COMMA);
        queue_char(REQ_DATA, CH_LBRACK);
        queue_char(REQ_DATA, CH_QUOTE);
        queue_char(REQ_DATA, CH_COMMA);
        queue_char(REQ_DATA, CH_LBRACE);
        queue_char(REQ_DATA, 8'h00);
        queue_char(REQ_DATA, 8'h20);
        queue_char(REQ_DATA, 8'h21);
        queue_char(REQ_DATA, CH_DEL);
        queue_char(REQ_DATA, 8'h7E);
        queue_char(REQ_DATA, 8'h80);
        queue_char(REQ_DATA, 8'hFF);
        queue_char(REQ_DATA, CH_RBRACE);
        queue_char(REQ_DATA, CH_RBRACK);
        queue_char(REQ_DATA, CH_RBRACE);
        queue_char(REQ_DATA, CH_RBRACK);
        queue_char(REQ_DATA, CH_RBRACE);
        queue_char(REQ_EOS, 8'hFF);
        queue_char(REQ_EOS, 8'h00);
        queue_char(REQ_DATA, CH_QUOTE);
        queue_char(REQ_EOS, CH_LBRACE);
        wait_drained();

        // Nest well past the indent cap, with a one-byte delimiter
        write_reg(REG_DELIM_BYTES, {$urandom, $urandom});
        write_reg(REG_DELIM_LEN, 64'd1);
        for (int k = 0; k < DEEP_OPENS; k++)
            queue_char(REQ_DATA, (k % 2) ? CH_LBRACK : CH_LBRACE);
        queue_char(REQ_DATA, CH_RBRACE);
        queue_char(REQ_DATA, CH_COMMA);
        queue_char(REQ_DATA, CH_RBRACK);
        queue_char(REQ_EOS, 8'h00);
        wait_drained();

        write_reg(REG_DELIM_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_DELIM_LEN, 64'd8);
        queue_random_doc(DOC_ITEMS);
        wait_drained();

        write_reg(REG_DELIM_BYTES, 64'h0);
        write_reg(REG_DELIM_LEN, 64'd15);
        queue_random_doc(DOC_ITEMS);
        wait_drained();

        write_reg(REG_DELIM_BYTES, {$urandom, $urandom});
        write_reg(REG_DELIM_LEN, 64'd0);
        queue_random_doc(DOC_ITEMS);
        wait_drained();

        write_reg(REG_DELIM_BYTES, {$urandom, $urandom});
        write_reg(REG_DELIM_LEN, 64'($urandom_range(15)));
        queue_random_doc(DOC_ITEMS);
        wait_drained();

        write_reg(REG_DELIM_BYTES, DELIM_BYTES_RESET);
        write_reg(REG_DELIM_LEN, 64'(DELIM_LEN_RESET));
        queue_random_doc(DOC_ITEMS);
        wait_drained();

        if (errors == 0)
            $display("tb_json_indent_stream_formatter_core: PASS");
        else
            $display("tb_json_indent_stream_formatter_core: FAIL");
        $finish;
    end

    // Timeout
    initial
    begin
        #10_000_000;
        $display("tb_json_indent_stream_formatter_core: FAIL");
        $finish;
    end

endmodule
